/* hdl/indirect_block_path_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the indirect block path
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDIRECT_BLOCK_PATH_MACROS_SVH
`define INDIRECT_BLOCK_PATH_MACROS_SVH

// same-cycle implication
`define IBP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define IBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/ibp_pkg.sv */
// ----------------------------------------------------------------------------
// ibp_pkg
// Types and constants shared by the indirect block path modules.
// ----------------------------------------------------------------------------
package ibp_pkg;

    localparam int LB_W          = 48;
    localparam int PPB_W         = 15;
    localparam int SLOT_W        = 14;
    localparam int META_W        = 50;
    localparam int SQ_W          = 2 * PPB_W;
    localparam int DIV_W         = 45;
    localparam int DIV_BITS      = 3;
    localparam int DIV_STAGES    = DIV_W / DIV_BITS;
    localparam int DIRECT_BLOCKS = 12;
    localparam int MAX_RESULTS   = 4;
    localparam int IDX_W         = 2;
    localparam logic [PPB_W-1:0] PPB_RESET = 15'd256;

    typedef enum logic [1:0] {
        ST_PATH    = 2'd0,
        ST_DIRECT  = 2'd1,
        ST_TOO_BIG = 2'd2
    } status_t;

    // item context carried down the pipeline
    typedef struct packed {
        status_t             kind;
        logic [1:0]          nlev;
        logic [META_W-1:0]   req;
        logic [META_W-1:0]   meta0;
        logic [PPB_W-1:0]    ppb;
        logic [SQ_W-1:0]     sq;
        logic [PPB_W-1:0]    r1;
    } item_t;

    // all results of one item
    typedef struct packed {
        status_t                                kind;
        logic [IDX_W-1:0]                       last_idx;
        logic [MAX_RESULTS-1:0][LB_W-1:0]       meta;
        logic [MAX_RESULTS-1:0][SLOT_W-1:0]     slot;
    } bundle_t;

endpackage

/* hdl/ibp_front.sv */
// ----------------------------------------------------------------------------
// ibp_front
// Magnitude, level classification and first meta-block number.
// ----------------------------------------------------------------------------
module ibp_front
    import ibp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [LB_W-1:0]   logical_block,
    input  logic [PPB_W-1:0]  ppb,
    output logic              out_valid,
    output item_t             out_item,
    output logic [DIV_W-1:0]  dividend
);

    logic [4:0] v_reg;

    // stage 0
    logic [LB_W-1:0]   lb0_reg;
    logic [PPB_W-1:0]  ppb0_reg;
    // stage 1
    logic [META_W-1:0] req1_reg;
    logic [LB_W-1:0]   mag1_reg;
    logic [PPB_W-1:0]  ppb1_reg;
    logic [SQ_W-1:0]   sq1_reg;
    // stage 2
    logic [META_W-1:0] req2_reg;
    logic [LB_W-1:0]   rem2_reg;
    logic              direct2_reg;
    logic [PPB_W-1:0]  ppb2_reg;
    logic [SQ_W-1:0]   sq2_reg;
    logic [DIV_W-1:0]  cube2_reg;
    // stage 3
    logic [META_W-1:0] req3_reg;
    logic [LB_W-1:0]   rem3_reg;
    logic              direct3_reg;
    logic [PPB_W-1:0]  ppb3_reg;
    logic [SQ_W-1:0]   sq3_reg;
    logic [SQ_W:0]     t2_reg;
    logic [DIV_W:0]    t3_reg;
    // stage 4
    item_t             item4_reg;
    item_t             item4_next;
    logic [DIV_W-1:0]  div4_reg;
    logic [DIV_W-1:0]  div4_next;

    logic [LB_W-1:0]   mag_next;
    logic [DIV_W:0]    sub;
    logic              lt1, lt2, lt3;
    logic [1:0]        k;
    logic [LB_W-1:0]   rem_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_valid};
    end

    always_comb
    begin
        mag_next = lb0_reg[LB_W-1] ? (LB_W'(0) - lb0_reg) : lb0_reg;
    end

    always_comb
    begin
        lt1 = rem3_reg < LB_W'(ppb3_reg);
        lt2 = rem3_reg < LB_W'(t2_reg);
        lt3 = rem3_reg < LB_W'(t3_reg);
        priority if (lt1)
        begin
            sub = '0;
            k   = 2'd0;
        end
        else if (lt2)
        begin
            sub = (DIV_W+1)'(ppb3_reg);
            k   = 2'd1;
        end
        else
        begin
            sub = (DIV_W+1)'(t2_reg);
            k   = 2'd2;
        end
        rem_sel = rem3_reg - LB_W'(sub);

        item4_next       = '0;
        item4_next.req   = req3_reg;
        item4_next.ppb   = ppb3_reg;
        item4_next.sq    = sq3_reg;
        item4_next.nlev  = k + 2'd1;
        item4_next.meta0 = META_W'(0)
                         - (META_W'(sub) + META_W'(DIRECT_BLOCKS) + META_W'(k));
        priority if (direct3_reg)
            item4_next.kind = ST_DIRECT;
        else if (!lt3)
            item4_next.kind = ST_TOO_BIG;
        else
            item4_next.kind = ST_PATH;
        div4_next = rem_sel[DIV_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lb0_reg     <= logical_block;
            ppb0_reg    <= ppb;

            req1_reg    <= META_W'(signed'(lb0_reg));
            mag1_reg    <= mag_next;
            ppb1_reg    <= ppb0_reg;
            sq1_reg     <= SQ_W'(ppb0_reg) * SQ_W'(ppb0_reg);

            req2_reg    <= req1_reg;
            rem2_reg    <= mag1_reg - LB_W'(DIRECT_BLOCKS);
            direct2_reg <= mag1_reg < LB_W'(DIRECT_BLOCKS);
            ppb2_reg    <= ppb1_reg;
            sq2_reg     <= sq1_reg;
            cube2_reg   <= DIV_W'(sq1_reg) * DIV_W'(ppb1_reg);

            req3_reg    <= req2_reg;
            rem3_reg    <= rem2_reg;
            direct3_reg <= direct2_reg;
            ppb3_reg    <= ppb2_reg;
            sq3_reg     <= sq2_reg;
            t2_reg      <= (SQ_W+1)'(ppb2_reg) + (SQ_W+1)'(sq2_reg);
            t3_reg      <= (DIV_W+1)'(ppb2_reg) + (DIV_W+1)'(sq2_reg)
                         + (DIV_W+1)'(cube2_reg);

            item4_reg   <= item4_next;
            div4_reg    <= div4_next;
        end
    end

    assign out_valid = v_reg[4];
    assign out_item  = item4_reg;
    assign dividend  = div4_reg;

endmodule

/* hdl/ibp_div.sv */
// ----------------------------------------------------------------------------
// ibp_div
// Pipelined restoring divider by the pointers-per-block count.
// ----------------------------------------------------------------------------
module ibp_div
    import ibp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  item_t             in_item,
    input  logic [DIV_W-1:0]  dividend,
    output logic              out_valid,
    output item_t             out_item,
    output logic [DIV_W-1:0]  quotient,
    output logic [PPB_W-1:0]  remainder
);

    logic [DIV_STAGES-1:0]  v_reg;
    item_t                  item_reg [DIV_STAGES];
    logic [PPB_W-1:0]       r_reg    [DIV_STAGES];
    logic [DIV_W-1:0]       q_reg    [DIV_STAGES];

    // shift DIV_BITS dividend bits into the partial remainder
    function automatic logic [PPB_W+DIV_W-1:0] div_step(
        input logic [PPB_W-1:0] r,
        input logic [DIV_W-1:0] q,
        input logic [PPB_W-1:0] d
    );
        logic [PPB_W:0]   t;
        logic [PPB_W-1:0] rr;
        logic [DIV_W-1:0] qq;
        rr = r;
        qq = q;
        for (int b = 0; b < DIV_BITS; b++)
        begin
            t  = {rr, qq[DIV_W-1]};
            qq = {qq[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                t     = t - {1'b0, d};
                qq[0] = 1'b1;
            end
            rr = t[PPB_W-1:0];
        end
        return {rr, qq};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[DIV_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg[0]         <= in_item;
            {r_reg[0], q_reg[0]} <= div_step('0, dividend, in_item.ppb);
        end
    end

    for (genvar s = 1; s < DIV_STAGES; s++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[s]          <= item_reg[s-1];
                {r_reg[s], q_reg[s]} <= div_step(r_reg[s-1], q_reg[s-1],
                                                 item_reg[s-1].ppb);
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_item  = item_reg[DIV_STAGES-1];
    assign quotient  = q_reg[DIV_STAGES-1];
    assign remainder = r_reg[DIV_STAGES-1];

endmodule

/* hdl/ibp_back.sv */
// ----------------------------------------------------------------------------
// ibp_back
// Meta-block numbers per level and early stop at the requested block.
// ----------------------------------------------------------------------------
module ibp_back
    import ibp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  item_t             in_item,
    input  logic [DIV_W-1:0]  q2,
    input  logic [PPB_W-1:0]  r2,
    output logic              out_valid,
    output bundle_t           out_bundle
);

    logic [3:0] v_reg;

    item_t             it1_reg, it2_reg, it3_reg;
    logic [DIV_W-1:0]  p2_reg;
    logic [SQ_W-1:0]   p1_reg, p1b_reg;
    logic [PPB_W-1:0]  dh1_reg, dh2_reg, dh3_reg;
    logic [PPB_W-1:0]  r2a_reg, r2b_reg, r2c_reg;
    logic [META_W-1:0] ma_reg, ma3_reg, mc_reg, mc3_reg, mb_reg;
    bundle_t           bundle_reg;
    bundle_t           bundle_next;

    logic [2:0][META_W-1:0] e_meta;
    logic [2:0][PPB_W-1:0]  e_off;
    logic [1:0]             ne;
    logic [IDX_W-1:0]       cnt;
    logic                   run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_comb
    begin
        e_meta = '0;
        e_off  = '0;
        unique case (it3_reg.nlev)
            2'd3:
            begin
                e_meta = {mb_reg, ma3_reg, it3_reg.meta0};
                e_off  = {it3_reg.r1, r2c_reg, dh3_reg};
                ne     = 2'd3;
            end
            2'd2:
            begin
                e_meta[0] = it3_reg.meta0;
                e_meta[1] = mc3_reg;
                e_off[0]  = r2c_reg;
                e_off[1]  = it3_reg.r1;
                ne        = 2'd2;
            end
            default:
            begin
                e_meta[0] = it3_reg.meta0;
                e_off[0]  = it3_reg.r1;
                ne        = 2'd1;
            end
        endcase

        // stop at the first level whose block is the one requested
        cnt = '0;
        run = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if (run && (2'(i) < ne) && (e_meta[i] != it3_reg.req))
                cnt = cnt + 1'b1;
            else
                run = 1'b0;
        end

        bundle_next      = '0;
        bundle_next.kind = it3_reg.kind;
        if (it3_reg.kind == ST_PATH)
        begin
            bundle_next.last_idx = cnt;
            bundle_next.meta[0]  = it3_reg.meta0[LB_W-1:0];
            bundle_next.slot[0]  = SLOT_W'(it3_reg.nlev - 2'd1);
            for (int i = 0; i < 3; i++)
            begin
                bundle_next.meta[i+1] = e_meta[i][LB_W-1:0];
                bundle_next.slot[i+1] = e_off[i][SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it1_reg    <= in_item;
            p2_reg     <= DIV_W'(q2[PPB_W-1:0]) * DIV_W'(in_item.sq);
            p1_reg     <= SQ_W'(r2) * SQ_W'(in_item.ppb);
            dh1_reg    <= q2[PPB_W-1:0];
            r2a_reg    <= r2;

            it2_reg    <= it1_reg;
            ma_reg     <= it1_reg.meta0 - META_W'(p2_reg) + META_W'(1);
            mc_reg     <= it1_reg.meta0 - META_W'(p1_reg) + META_W'(1);
            p1b_reg    <= p1_reg;
            dh2_reg    <= dh1_reg;
            r2b_reg    <= r2a_reg;

            it3_reg    <= it2_reg;
            mb_reg     <= ma_reg - META_W'(p1b_reg) + META_W'(1);
            ma3_reg    <= ma_reg;
            mc3_reg    <= mc_reg;
            dh3_reg    <= dh2_reg;
            r2c_reg    <= r2b_reg;

            bundle_reg <= bundle_next;
        end
    end

    assign out_valid  = v_reg[3];
    assign out_bundle = bundle_reg;

endmodule

/* hdl/ibp_ser.sv */
// ----------------------------------------------------------------------------
// ibp_ser
// Output register that hands out the results of one item in order.
// ----------------------------------------------------------------------------
module ibp_ser
    import ibp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  bundle_t            in_bundle,
    output logic               en,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [LB_W-1:0]    meta_block,
    output logic [SLOT_W-1:0]  slot_offset,
    output logic               last
);

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    bundle_t          bundle_reg;

    assign last      = idx_reg == bundle_reg.last_idx;
    // advance the pipeline unless a result is still pending
    assign en        = !busy_reg || (out_ready && last);
    assign out_valid = busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (en)
        begin
            busy_next = in_valid;
            idx_next  = '0;
        end
        else if (out_ready)
            idx_next = idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            bundle_reg <= in_bundle;
    end

    assign status      = bundle_reg.kind;
    assign meta_block  = bundle_reg.meta[idx_reg];
    assign slot_offset = bundle_reg.slot[idx_reg];

endmodule

/* hdl/indirect_block_path.sv */
// ----------------------------------------------------------------------------
// indirect_block_path
// Indirect block path lookup for a block-mapped file.
// ----------------------------------------------------------------------------
// One logical block number enters per transaction; results leave one per cycle
// while out_ready is high, one to four per item (a single result for a direct or
// too-big block). The pipeline takes a new item every cycle while the output is
// free; the output register hands out an item's results in turn and holds
// the pipeline until the last is taken. An item passes classification, two
// pipelined dividers by the pointers-per-block count of 15 stages each, and
// the meta-block arithmetic on its way to the first result.
// ptrs_per_block is sampled with each item as it enters.
`include "indirect_block_path_macros.svh"

module indirect_block_path
    import ibp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [LB_W-1:0]    logical_block,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [LB_W-1:0]    meta_block,
    output logic [SLOT_W-1:0]  slot_offset,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [PPB_W-1:0]   cfg_data
);

    logic [PPB_W-1:0] ppb_reg;
    logic             en;

    logic             f_valid;
    item_t            f_item;
    logic [DIV_W-1:0] f_div;
    logic             d1_valid;
    item_t            d1_item;
    item_t            d1_item_r1;
    logic [DIV_W-1:0] d1_q;
    logic [PPB_W-1:0] d1_r;
    logic             d2_valid;
    item_t            d2_item;
    logic [DIV_W-1:0] d2_q;
    logic [PPB_W-1:0] d2_r;
    logic             b_valid;
    bundle_t          b_bundle;

    assign cfg_ready = 1'b1;
    assign in_ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ppb_reg <= PPB_RESET;
        else if (cfg_valid)
            ppb_reg <= cfg_data;
    end

    ibp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .logical_block (logical_block),
        .ppb           (ppb_reg),
        .out_valid     (f_valid),
        .out_item      (f_item),
        .dividend      (f_div)
    );

    ibp_div u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_item   (f_item),
        .dividend  (f_div),
        .out_valid (d1_valid),
        .out_item  (d1_item),
        .quotient  (d1_q),
        .remainder (d1_r)
    );

    always_comb
    begin
        d1_item_r1    = d1_item;
        d1_item_r1.r1 = d1_r;
    end

    ibp_div u_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d1_valid),
        .in_item   (d1_item_r1),
        .dividend  (d1_q),
        .out_valid (d2_valid),
        .out_item  (d2_item),
        .quotient  (d2_q),
        .remainder (d2_r)
    );

    ibp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (d2_valid),
        .in_item    (d2_item),
        .q2         (d2_q),
        .r2         (d2_r),
        .out_valid  (b_valid),
        .out_bundle (b_bundle)
    );

    ibp_ser u_ser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (b_valid),
        .in_bundle   (b_bundle),
        .en          (en),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .meta_block  (meta_block),
        .slot_offset (slot_offset),
        .last        (last)
    );

    `IBP_ASSERT_NEXT(a_more_results, out_valid && out_ready && !last, out_valid)
    `IBP_ASSERT_SAME(a_stall_holds_input, out_valid && !out_ready, !in_ready)
    `IBP_ASSERT_SAME(a_single_non_path, out_valid && (status != ST_PATH), last)

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Indirect block path testbench
// Drives signed logical block numbers through the valid/ready input, walks
// the block map in a local predictor and checks every result transaction
// field by field. Phases run several pointers-per-block settings, with
// random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ibp_pkg::*;

    typedef struct {
        status_t     st;
        logic [47:0] meta;
        logic [13:0] slot;
        logic        last;
    } path_ent_t;

    typedef struct packed {
        logic        typed;
        logic [1:0]  st;
        logic [47:0] lb;
    } dir_row_t;

    localparam int N_DIRECTED = 19;
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{1'b1, ST_DIRECT,  48'd0},
        '{1'b1, ST_DIRECT,  48'd11},
        '{1'b1, ST_DIRECT,  48'hFFFF_FFFF_FFF5},
        '{1'b1, ST_DIRECT,  48'hFFFF_FFFF_FFFE},
        '{1'b0, ST_PATH,    48'd12},
        '{1'b0, ST_PATH,    48'hFFFF_FFFF_FFF4},
        '{1'b0, ST_PATH,    48'd267},
        '{1'b0, ST_PATH,    48'd268},
        '{1'b0, ST_PATH,    48'hFFFF_FFFF_FEF4},
        '{1'b0, ST_PATH,    48'd65803},
        '{1'b0, ST_PATH,    48'd65804},
        '{1'b0, ST_PATH,    48'hFFFF_FFFE_FEF4},
        '{1'b0, ST_PATH,    48'd16843019},
        '{1'b1, ST_TOO_BIG, 48'd16843020},
        '{1'b1, ST_TOO_BIG, 48'h7FFF_FFFF_FFFF},
        '{1'b1, ST_TOO_BIG, 48'h8000_0000_0000},
        '{1'b1, ST_TOO_BIG, 48'h5555_5555_5555},
        '{1'b1, ST_TOO_BIG, 48'hAAAA_AAAA_AAAA},
        '{1'b0, ST_PATH,    48'd70000}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [LB_W-1:0]    logical_block;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic [LB_W-1:0]    meta_block;
    logic [SLOT_W-1:0]  slot_offset;
    logic               last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [PPB_W-1:0]   cfg_data;

    path_ent_t          pending_paths[$];
    logic [PPB_W-1:0]   ppb_shadow;
    logic               no_idle;
    int                 fail_count;

    indirect_block_path dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .logical_block(logical_block),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .meta_block   (meta_block),
        .slot_offset  (slot_offset),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // walk the block map for one logical block number
    function automatic int walk_path(input logic [47:0] lb, input logic [14:0] ppb,
                                     output path_ent_t res[4]);
        longint          req;
        longint          meta;
        longint unsigned mag;
        longint unsigned p;
        longint unsigned rem;
        longint unsigned span;
        longint unsigned nxt;
        longint unsigned off;
        int              lvl;
        int              n;
        for (int i = 0; i < 4; i++)
            res[i] = '{ST_PATH, 48'd0, 14'd0, 1'b0};
        req = longint'(signed'(lb));
        mag = (req < 0) ? -req : req;
        p = ppb;
        if (mag < DIRECT_BLOCKS)
        begin
            res[0] = '{ST_DIRECT, 48'd0, 14'd0, 1'b1};
            return 1;
        end
        rem = mag - DIRECT_BLOCKS;
        span = 1;
        lvl = 3;
        while (1)
        begin
            if (lvl == 0)
            begin
                res[0] = '{ST_TOO_BIG, 48'd0, 14'd0, 1'b1};
                return 1;
            end
            nxt = span * p;
            if (rem < nxt)
                break;
            span = nxt;
            lvl--;
            rem -= span;
        end
        meta = -longint'(mag - rem + (3 - lvl));
        res[0] = '{ST_PATH, meta[47:0], 14'(3 - lvl), 1'b0};
        n = 1;
        for (; lvl <= 3; lvl++)
        begin
            if (meta == req)
                break;
            off = (span != 0 && p != 0) ? (rem / span) % p : 0;
            res[n] = '{ST_PATH, meta[47:0], off[13:0], 1'b0};
            n++;
            meta = meta - longint'(off * span) + 1;
            if (p != 0)
                span /= p;
        end
        res[n-1].last = 1'b1;
        return n;
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // well-formed block numbers in each indirection region, meta-block
    // requests taken from a real path, and raw noise
    function automatic logic [47:0] pick_block(input logic [14:0] ppb);
        longint unsigned p;
        longint unsigned base;
        longint unsigned size;
        longint unsigned ofs;
        path_ent_t       res[4];
        int              n;
        int              kind;
        int              region;
        p = ppb;
        kind = $urandom_range(0, 99);
        region = $urandom_range(0, 4);
        base = 0;
        size = DIRECT_BLOCKS;
        if (region >= 1)
        begin
            base = DIRECT_BLOCKS;
            size = p;
        end
        if (region >= 2)
        begin
            base += p;
            size = p * p;
        end
        if (region >= 3)
        begin
            base += p * p;
            size = p * p * p;
        end
        if (region == 4)
        begin
            base += p * p * p;
            size = 64'h8000_0000_0000 - base;
        end
        case ($urandom_range(0, 3))
            0: ofs = 0;
            1: ofs = size - 1;
            default: ofs = {$urandom, $urandom} % size;
        endcase
        if (kind < 10)
            return rand48();
        if (kind < 40)
        begin
            n = walk_path(48'(base + ofs), ppb, res);
            if (res[0].st == ST_PATH)
                return res[$urandom_range(0, n - 1)].meta;
        end
        if (kind < 55)
            return 48'(-longint'(base + ofs));
        return 48'(base + ofs);
    endfunction

    task automatic send_block(input logic [47:0] lb, input logic typed, input status_t st);
        int        gap;
        int        n;
        path_ent_t res[4];
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        logical_block <= lb;
        do @(posedge clk); while (!in_ready);
        if (typed)
            pending_paths.push_back('{st, 48'd0, 14'd0, 1'b1});
        else
        begin
            n = walk_path(lb, ppb_shadow, res);
            for (int i = 0; i < n; i++)
                pending_paths.push_back(res[i]);
        end
    endtask

    task automatic write_ppb(input logic [14:0] val);
        in_valid <= 1'b0;
        while (pending_paths.size() != 0)
            @(posedge clk);
        repeat (45) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ppb_shadow = val;
    endtask

    task automatic random_phase(input logic [14:0] val, input int count);
        write_ppb(val);
        for (int i = 0; i < count; i++)
        begin
            if (i % 12 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_block(pick_block(ppb_shadow), 1'b0, ST_PATH);
        end
    endtask

    // result side: stall, then take one transaction and check it
    initial
    begin
        int        stall;
        path_ent_t exp_ent;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (pending_paths.size() == 0)
            begin
                $error("unexpected result: status %0d meta %h", status, meta_block);
                fail_count++;
            end
            else
            begin
                exp_ent = pending_paths.pop_front();
                if (status !== exp_ent.st)
                begin
                    $error("status: expected %0d, got %0d", exp_ent.st, status);
                    fail_count++;
                end
                if (meta_block !== exp_ent.meta)
                begin
                    $error("meta_block: expected %h, got %h", exp_ent.meta, meta_block);
                    fail_count++;
                end
                if (slot_offset !== exp_ent.slot)
                begin
                    $error("slot_offset: expected %0d, got %0d", exp_ent.slot, slot_offset);
                    fail_count++;
                end
                if (last !== exp_ent.last)
                begin
                    $error("last: expected %0d, got %0d", exp_ent.last, last);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        int waited;
        fail_count = 0;
        no_idle = 1'b0;
        ppb_shadow = PPB_RESET;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        logical_block <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_block(DIRECTED[i].lb, DIRECTED[i].typed, status_t'(DIRECTED[i].st));

        random_phase(15'd16384, 30);
        random_phase(15'd1000, 30);
        random_phase(15'd257, 30);
        random_phase(15'd4096, 30);
        random_phase(15'd256, 30);

        in_valid <= 1'b0;
        waited = 0;
        while (pending_paths.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending_paths.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ibp_pkg.sv
hdl/ibp_front.sv
hdl/ibp_div.sv
hdl/ibp_back.sv
hdl/ibp_ser.sv
hdl/indirect_block_path.sv
tb/tb.sv
